[rtl/core/amd_pkg.sv]
// Package for the address map and decode unit: channel payload types,
// configuration register set, slave codes and fixed map constants.
// No dependencies.
`default_nettype none

package amd_pkg;

    localparam int ADDR_W     = 24;
    localparam int SLAVE_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [SLAVE_W-1:0] {
        SLV_SYS     = 4'd0,
        SLV_EEPROM  = 4'd1,
        SLV_MEMCTL  = 4'd2,
        SLV_DMA     = 4'd3,
        SLV_SOUND   = 4'd4,
        SLV_BLIT    = 4'd5,
        SLV_GFX     = 4'd6,
        SLV_PAGECTL = 4'd7,
        SLV_FLASH   = 4'd8,
        SLV_CHIPRAM = 4'd9
    } t_slave;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROM_PAGE      = 3'd0,
        CFG_SWRAM_ENABLE  = 3'd1,
        CFG_DEBUG_SHADOW  = 3'd2,
        CFG_MOS_SHADOW    = 3'd3,
        CFG_TURBO_MASK    = 3'd4,
        CFG_PAGING_ENABLE = 3'd5,
        CFG_PAGING_PAGE   = 3'd6,
        CFG_MAP_SELECT    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [ADDR_W-1:0] logical_address;
    } t_in;

    typedef struct packed {
        logic [ADDR_W-1:0] physical_address;
        logic [SLAVE_W-1:0] target_slave;
    } t_out;

    typedef struct packed {
        t_cfg_idx              index;
        logic [CFG_DATA_W-1:0] wdata;
    } t_cfg_wr;

    typedef struct packed {
        logic [3:0]  rom_page;
        logic        swram_enable;
        logic        debug_shadow;
        logic        mos_shadow;
        logic [7:0]  turbo_mask;
        logic        paging_enable;
        logic [15:0] paging_page;
        logic        map_select;
    } t_cfg;

    localparam logic [ADDR_W-1:0] SWROM_BASE_M0  = 24'h8E0000;
    localparam logic [ADDR_W-1:0] SWROM_BASE_M1  = 24'h8C0000;
    localparam logic [ADDR_W-1:0] SWRAM_BASE_M0  = 24'h7E0000;
    localparam logic [ADDR_W-1:0] SWRAM_BASE_M1  = 24'h7C0000;
    localparam logic [ADDR_W-1:0] DBG_LOW_BASE   = 24'h7E8000;
    localparam logic [ADDR_W-1:0] DBG_MOS_M0     = 24'h9FC000;
    localparam logic [ADDR_W-1:0] DBG_MOS_M1     = 24'h9DC000;
    localparam logic [ADDR_W-1:0] SWMOS_BASE_M0  = 24'h7F0000;
    localparam logic [ADDR_W-1:0] SWMOS_BASE_M1  = 24'h7D0000;
    localparam logic [ADDR_W-1:0] MOS_BASE_M1    = 24'h9D0000;

    localparam logic [ADDR_W-1:0] MEMCTL_BASE    = 24'hFFFE30;
    localparam logic [ADDR_W-1:0] EEPROM_ADDR    = 24'hFFFE36;
    localparam logic [3:0]        MEMCTL_HOLE    = 4'h4;
    localparam logic [ADDR_W-1:0] DMA_BASE       = 24'hFEFC90;
    localparam logic [ADDR_W-1:0] SOUND_BASE     = 24'hFEFC80;
    localparam logic [ADDR_W-1:0] BLIT_BASE_A    = 24'hFEFC60;
    localparam logic [ADDR_W-1:0] BLIT_BASE_B    = 24'hFEFC70;
    localparam logic [ADDR_W-1:0] BLIT_BASE_C    = 24'hFEFCA0;
    localparam logic [ADDR_W-1:0] GFX_BASE       = 24'hFEFCB0;
    localparam logic [ADDR_W-1:0] PAGE_REG_LO    = 24'hFFFCFD;
    localparam logic [ADDR_W-1:0] PAGE_REG_HI    = 24'hFFFCFE;
    localparam logic [ADDR_W-1:0] FLASH_LO       = 24'h800000;
    localparam logic [ADDR_W-1:0] FLASH_HI       = 24'hFE0000;
    localparam logic [7:0]        SYS_BANK       = 8'hFF;

endpackage

`default_nettype wire

[rtl/core/amd_stream_if.sv]
// Valid/ready channel with a typed payload.
// Payload types come from amd_pkg.
`default_nettype none

interface amd_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/amd_translate.sv]
// Logical to physical address translation for bank FF windows.
// Depends on amd_pkg.
`default_nettype none

module amd_translate (
    input  wire logic [amd_pkg::ADDR_W-1:0] i_addr,
    input  wire amd_pkg::t_cfg              i_cfg,
    output logic [amd_pkg::ADDR_W-1:0]      o_addr
);
    logic [15:0]                 w_lo;
    logic                        w_bank_ff;
    logic                        w_sw_win;
    logic                        w_mos_win;
    logic                        w_sw_mapped;
    logic [amd_pkg::ADDR_W-1:0]  w_sw_base;
    logic [amd_pkg::ADDR_W-1:0]  w_sw_addr;
    logic [amd_pkg::ADDR_W-1:0]  w_mos_addr;
    logic                        w_mos_hit;

    assign w_lo      = i_addr[15:0];
    assign w_bank_ff = (i_addr[23:16] == amd_pkg::SYS_BANK);
    assign w_sw_win  = (w_lo[15:14] == 2'b10) && i_cfg.swram_enable;
    assign w_mos_win = ((w_lo >= 16'hC000) && (w_lo < 16'hFC00)) || (w_lo >= 16'hFF00);
    assign w_sw_mapped = i_cfg.rom_page[3] || !i_cfg.rom_page[2];

    always_comb begin
        if (i_cfg.rom_page[0]) begin
            w_sw_base = i_cfg.map_select ? amd_pkg::SWROM_BASE_M1 : amd_pkg::SWROM_BASE_M0;
        end else begin
            w_sw_base = i_cfg.map_select ? amd_pkg::SWRAM_BASE_M1 : amd_pkg::SWRAM_BASE_M0;
        end
        w_sw_addr = w_sw_base + {7'd0, i_cfg.rom_page[3:1], i_addr[13:0]};
    end

    always_comb begin
        w_mos_hit  = 1'b1;
        w_mos_addr = i_addr;
        priority if (i_cfg.debug_shadow) begin
            if (w_lo[15:12] == 4'hC) begin
                w_mos_addr = amd_pkg::DBG_LOW_BASE + {12'd0, w_lo[11:0]};
            end else begin
                w_mos_addr = (i_cfg.map_select ? amd_pkg::DBG_MOS_M1 : amd_pkg::DBG_MOS_M0)
                             + {10'd0, w_lo[13:0]};
            end
        end else if (i_cfg.mos_shadow) begin
            w_mos_addr = (i_cfg.map_select ? amd_pkg::SWMOS_BASE_M1 : amd_pkg::SWMOS_BASE_M0)
                         + {10'd0, w_lo[13:0]};
        end else if (i_cfg.map_select) begin
            w_mos_addr = amd_pkg::MOS_BASE_M1 + {10'd0, w_lo[13:0]};
        end else begin
            w_mos_hit = 1'b0;
        end
    end

    always_comb begin
        o_addr = i_addr;
        priority if (!w_bank_ff) begin
            o_addr = i_addr;
        end else if (w_sw_win) begin
            if (w_sw_mapped) begin
                o_addr = w_sw_addr;
            end
        end else if (w_mos_win) begin
            if (w_mos_hit) begin
                o_addr = w_mos_addr;
            end
        end else if (!w_lo[15]) begin
            if (i_cfg.turbo_mask[w_lo[14:12]]) begin
                o_addr = {9'd0, w_lo[14:0]};
            end
        end else if ((w_lo[15:8] == 8'hFD) && i_cfg.paging_enable) begin
            o_addr = {i_cfg.paging_page, w_lo[7:0]};
        end else begin
            o_addr = i_addr;
        end
    end
endmodule

`default_nettype wire

[rtl/core/amd_decode.sv]
// Physical address decode to a target slave code.
// Depends on amd_pkg.
`default_nettype none

module amd_decode (
    input  wire logic [amd_pkg::ADDR_W-1:0] i_addr,
    input  wire logic                       i_paging_enable,
    output amd_pkg::t_slave                 o_slave
);
    logic [amd_pkg::ADDR_W-1:0] w_hi;

    assign w_hi = {i_addr[23:4], 4'h0};

    always_comb begin
        priority if (i_addr == amd_pkg::MEMCTL_BASE) begin
            o_slave = amd_pkg::SLV_SYS;
        end else if (i_addr == amd_pkg::EEPROM_ADDR) begin
            o_slave = amd_pkg::SLV_EEPROM;
        end else if ((w_hi == amd_pkg::MEMCTL_BASE) && (i_addr[3:0] != amd_pkg::MEMCTL_HOLE)) begin
            o_slave = amd_pkg::SLV_MEMCTL;
        end else if (w_hi == amd_pkg::DMA_BASE) begin
            o_slave = amd_pkg::SLV_DMA;
        end else if (w_hi == amd_pkg::SOUND_BASE) begin
            o_slave = amd_pkg::SLV_SOUND;
        end else if ((w_hi == amd_pkg::BLIT_BASE_A) || (w_hi == amd_pkg::BLIT_BASE_B)
                     || (w_hi == amd_pkg::BLIT_BASE_C)) begin
            o_slave = amd_pkg::SLV_BLIT;
        end else if (w_hi == amd_pkg::GFX_BASE) begin
            o_slave = amd_pkg::SLV_GFX;
        end else if (((i_addr == amd_pkg::PAGE_REG_LO) || (i_addr == amd_pkg::PAGE_REG_HI))
                     && i_paging_enable) begin
            o_slave = amd_pkg::SLV_PAGECTL;
        end else if (i_addr[23:16] == amd_pkg::SYS_BANK) begin
            o_slave = amd_pkg::SLV_SYS;
        end else if ((i_addr >= amd_pkg::FLASH_LO) && (i_addr <= amd_pkg::FLASH_HI)) begin
            o_slave = amd_pkg::SLV_FLASH;
        end else begin
            o_slave = amd_pkg::SLV_CHIPRAM;
        end
    end
endmodule

`default_nettype wire

[rtl/core/address_map_and_decode_unit.sv]
// Address map and decode unit: logical address in, physical address and slave out.
// Each accepted address passes through the input register and then the result register.
// Throughput: one address per cycle while the output is ready; translate and decode sit between the two registers.
// Reset (synchronous, active low) clears both valid flags and all map registers.
// Depends on amd_pkg, amd_stream_if, amd_translate, amd_decode.
`default_nettype none

module address_map_and_decode_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    amd_stream_if.sink   i_in,
    amd_stream_if.sink   i_cfg,
    amd_stream_if.source o_out
);
    amd_pkg::t_cfg              r_cfg;
    logic                       r_s1_valid;
    logic [amd_pkg::ADDR_W-1:0] r_s1_addr;
    logic                       r_out_valid;
    amd_pkg::t_out              r_out;
    amd_pkg::t_out              n_out;
    logic [amd_pkg::ADDR_W-1:0] w_phys;
    amd_pkg::t_slave            w_slave;
    amd_pkg::t_cfg_wr           w_cfg_wr;
    logic                       w_s1_adv;
    logic                       w_in_xfer;

    assign w_s1_adv   = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || w_s1_adv;
    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign w_cfg_wr   = i_cfg.data;

    amd_translate u_translate (
        .i_addr (r_s1_addr),
        .i_cfg  (r_cfg),
        .o_addr (w_phys)
    );

    amd_decode u_decode (
        .i_addr          (w_phys),
        .i_paging_enable (r_cfg.paging_enable),
        .o_slave         (w_slave)
    );

    assign n_out = {w_phys, w_slave};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (w_s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_addr <= i_in.data.logical_address;
        end
        if (w_s1_adv && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            unique case (w_cfg_wr.index)
                amd_pkg::CFG_ROM_PAGE:      r_cfg.rom_page      <= w_cfg_wr.wdata[3:0];
                amd_pkg::CFG_SWRAM_ENABLE:  r_cfg.swram_enable  <= w_cfg_wr.wdata[0];
                amd_pkg::CFG_DEBUG_SHADOW:  r_cfg.debug_shadow  <= w_cfg_wr.wdata[0];
                amd_pkg::CFG_MOS_SHADOW:    r_cfg.mos_shadow    <= w_cfg_wr.wdata[0];
                amd_pkg::CFG_TURBO_MASK:    r_cfg.turbo_mask    <= w_cfg_wr.wdata[7:0];
                amd_pkg::CFG_PAGING_ENABLE: r_cfg.paging_enable <= w_cfg_wr.wdata[0];
                amd_pkg::CFG_PAGING_PAGE:   r_cfg.paging_page   <= w_cfg_wr.wdata;
                amd_pkg::CFG_MAP_SELECT:    r_cfg.map_select    <= w_cfg_wr.wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

`ifndef SYNTHESIS
    a_in_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> r_s1_valid)
        else $error("accepted address did not reach the input register");

    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_s1_adv) |=> r_out_valid)
        else $error("input register item did not reach the result register");

    a_pagectl_needs_paging: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.target_slave == amd_pkg::SLV_PAGECTL)) |-> r_cfg.paging_enable)
        else $error("paging register decoded with paging disabled");

    a_flash_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.target_slave == amd_pkg::SLV_FLASH))
        |-> ((r_out.physical_address >= amd_pkg::FLASH_LO)
             && (r_out.physical_address <= amd_pkg::FLASH_HI)))
        else $error("flash decode outside the flash range");
`endif
endmodule

`default_nettype wire

[verif/address_map_and_decode_unit_test.sv]
// Testbench for address_map_and_decode_unit: random and directed logical addresses
// under changing map settings, each result checked against an in-bench route predictor.
// Depends on amd_pkg, amd_stream_if and the unit itself.
`timescale 1ns / 100ps

module address_map_and_decode_unit_test;

    logic i_clk;
    logic i_rst_n;

    amd_stream_if #(.t_payload(amd_pkg::t_in))     in_ch  ();
    amd_stream_if #(.t_payload(amd_pkg::t_cfg_wr)) cfg_ch ();
    amd_stream_if #(.t_payload(amd_pkg::t_out))    out_ch ();

    address_map_and_decode_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    localparam int STALL_LIMIT = 2000;

    amd_pkg::t_cfg map_cfg;
    logic [23:0]   addr_pending[$];
    amd_pkg::t_out expected_route[$];
    int            error_count = 0;
    int            send_gap = 0;
    int            recv_gap = 0;
    int            stall_cycles = 0;
    int            queued_count = 0;
    int            checked_count = 0;
    bit            idle_on = 1'b0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic amd_pkg::t_out predict_route(input amd_pkg::t_cfg c,
                                                    input logic [23:0] a);
        logic [15:0]   lo;
        logic [23:0]   p;
        logic [23:0]   base;
        amd_pkg::t_out r;
        lo = a[15:0];
        p  = a;
        if (a[23:16] == 8'hFF) begin
            if (lo >= 16'h8000 && lo < 16'hC000 && c.swram_enable) begin
                if (c.rom_page < 4'd4 || c.rom_page >= 4'd8) begin
                    if (c.rom_page[0])
                        base = c.map_select ? 24'h8C0000 : 24'h8E0000;
                    else
                        base = c.map_select ? 24'h7C0000 : 24'h7E0000;
                    p = base + {7'd0, c.rom_page[3:1], 14'd0} + {10'd0, a[13:0]};
                end
            end else if ((lo >= 16'hC000 && lo < 16'hFC00) || lo >= 16'hFF00) begin
                if (c.debug_shadow) begin
                    if (lo[15:12] == 4'hC)
                        p = 24'h7E8000 + {12'd0, lo[11:0]};
                    else
                        p = (c.map_select ? 24'h9DC000 : 24'h9FC000) + {10'd0, lo[13:0]};
                end else if (c.mos_shadow) begin
                    p = (c.map_select ? 24'h7D0000 : 24'h7F0000) + {10'd0, lo[13:0]};
                end else if (c.map_select) begin
                    p = 24'h9D0000 + {10'd0, lo[13:0]};
                end
            end else if (lo < 16'h8000) begin
                if (c.turbo_mask[lo[14:12]])
                    p = {9'd0, lo[14:0]};
            end else if (lo[15:8] == 8'hFD && c.paging_enable) begin
                p = {c.paging_page, lo[7:0]};
            end
        end
        r.physical_address = p;
        if (p == 24'hFFFE30)
            r.target_slave = amd_pkg::SLV_SYS;
        else if (p == 24'hFFFE36)
            r.target_slave = amd_pkg::SLV_EEPROM;
        else if (p[23:4] == 20'hFFFE3 && p[3:0] != 4'h4)
            r.target_slave = amd_pkg::SLV_MEMCTL;
        else if (p[23:4] == 20'hFEFC9)
            r.target_slave = amd_pkg::SLV_DMA;
        else if (p[23:4] == 20'hFEFC8)
            r.target_slave = amd_pkg::SLV_SOUND;
        else if (p[23:4] == 20'hFEFC6 || p[23:4] == 20'hFEFC7 || p[23:4] == 20'hFEFCA)
            r.target_slave = amd_pkg::SLV_BLIT;
        else if (p[23:4] == 20'hFEFCB)
            r.target_slave = amd_pkg::SLV_GFX;
        else if ((p == 24'hFFFCFD || p == 24'hFFFCFE) && c.paging_enable)
            r.target_slave = amd_pkg::SLV_PAGECTL;
        else if (p[23:16] == 8'hFF)
            r.target_slave = amd_pkg::SLV_SYS;
        else if (p >= 24'h800000 && p <= 24'hFE0000)
            r.target_slave = amd_pkg::SLV_FLASH;
        else
            r.target_slave = amd_pkg::SLV_CHIPRAM;
        return r;
    endfunction

    function automatic logic [23:0] rand_addr();
        logic [31:0] r;
        int          pick;
        r    = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return r[23:0];
        else if (pick < 55)
            return {8'hFF, r[15:0]};
        else if (pick < 65)
            return {8'hFF, 8'hFC + 8'($urandom_range(0, 3)), r[7:0]};
        else if (pick < 75)
            return {16'hFEFC, 4'h6 + 4'($urandom_range(0, 5)), r[3:0]};
        else if (pick < 80)
            return {20'hFFFE3, r[3:0]};
        else if (pick < 85)
            return {20'hFFFCF, r[3:0]};
        else if (pick < 92) begin
            case ($urandom_range(0, 6))
                0: return 24'h7FFFFF;
                1: return 24'h800000;
                2: return 24'h800001;
                3: return 24'hFDFFFF;
                4: return 24'hFE0000;
                5: return 24'hFE0001;
                default: return 24'hFEFFFF;
            endcase
        end
        return {9'h1FE, r[14:0]};
    endfunction

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        error_count++;
        if (error_count <= 40)
            $display("mismatch: %s got %h want %h", what, got, want);
    endtask

    // Write all eight map registers back to back; caller sits on a rising edge.
    task automatic load_map(input amd_pkg::t_cfg c);
        amd_pkg::t_cfg_wr wr;
        logic [31:0]      r;
        int               k;
        for (k = 0; k < 8; k++) begin
            r        = $urandom;
            wr.index = amd_pkg::t_cfg_idx'(k);
            wr.wdata = r[15:0];
            case (wr.index)
                amd_pkg::CFG_ROM_PAGE:      wr.wdata[3:0] = c.rom_page;
                amd_pkg::CFG_SWRAM_ENABLE:  wr.wdata[0]   = c.swram_enable;
                amd_pkg::CFG_DEBUG_SHADOW:  wr.wdata[0]   = c.debug_shadow;
                amd_pkg::CFG_MOS_SHADOW:    wr.wdata[0]   = c.mos_shadow;
                amd_pkg::CFG_TURBO_MASK:    wr.wdata[7:0] = c.turbo_mask;
                amd_pkg::CFG_PAGING_ENABLE: wr.wdata[0]   = c.paging_enable;
                amd_pkg::CFG_PAGING_PAGE:   wr.wdata      = c.paging_page;
                amd_pkg::CFG_MAP_SELECT:    wr.wdata[0]   = c.map_select;
                default: ;
            endcase
            cfg_ch.data  <= wr;
            cfg_ch.valid <= 1'b1;
            do @(posedge i_clk); while (!cfg_ch.ready);
            case (wr.index)
                amd_pkg::CFG_ROM_PAGE:      map_cfg.rom_page      = wr.wdata[3:0];
                amd_pkg::CFG_SWRAM_ENABLE:  map_cfg.swram_enable  = wr.wdata[0];
                amd_pkg::CFG_DEBUG_SHADOW:  map_cfg.debug_shadow  = wr.wdata[0];
                amd_pkg::CFG_MOS_SHADOW:    map_cfg.mos_shadow    = wr.wdata[0];
                amd_pkg::CFG_TURBO_MASK:    map_cfg.turbo_mask    = wr.wdata[7:0];
                amd_pkg::CFG_PAGING_ENABLE: map_cfg.paging_enable = wr.wdata[0];
                amd_pkg::CFG_PAGING_PAGE:   map_cfg.paging_page   = wr.wdata;
                amd_pkg::CFG_MAP_SELECT:    map_cfg.map_select    = wr.wdata[0];
                default: ;
            endcase
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (checked_count < queued_count);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                expected_route.push_back(predict_route(map_cfg, in_ch.data.logical_address));
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (addr_pending.size() > 0) begin
                    in_ch.data  <= '{logical_address: addr_pending.pop_front()};
                    in_ch.valid <= 1'b1;
                    if (idle_on && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 12);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        amd_pkg::t_out want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                checked_count++;
                if (expected_route.size() == 0) begin
                    report_mismatch("unexpected result", out_ch.data.physical_address, '0);
                end else begin
                    want = expected_route.pop_front();
                    if (out_ch.data.physical_address !== want.physical_address)
                        report_mismatch("physical_address", out_ch.data.physical_address,
                                        want.physical_address);
                    if (out_ch.data.target_slave !== want.target_slave)
                        report_mismatch("target_slave", 24'(out_ch.data.target_slave),
                                        24'(want.target_slave));
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0)
                    recv_gap = $urandom_range(1, 12);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        amd_pkg::t_cfg c;
        int            ph;
        int            k;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        out_ch.ready = 1'b0;
        map_cfg      = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset map: register windows, holes, flash edges
        idle_on = 1'b1;
        load_map('0);
        addr_pending = '{24'h000000, 24'hFFFFFF, 24'hFFFE30, 24'hFFFE34, 24'hFFFE36,
                         24'hFFFE3F, 24'hFEFC90, 24'hFEFC80, 24'hFEFC65, 24'hFEFC7A,
                         24'hFEFCA5, 24'hFEFCBF, 24'hFFFCFD, 24'hFFFCFF, 24'h800000,
                         24'hFE0000, 24'hFE0001, 24'h7FFFFF};
        queued_count += addr_pending.size();
        wait_drained();

        // everything enabled, unmapped sideways page, map 1
        c = '{rom_page: 4'd5, swram_enable: 1'b1, debug_shadow: 1'b1, mos_shadow: 1'b1,
              turbo_mask: 8'hFF, paging_enable: 1'b1, paging_page: 16'hFFFF,
              map_select: 1'b1};
        load_map(c);
        addr_pending = '{24'hFF8000, 24'hFFC000, 24'hFFFBFF, 24'hFFFC00, 24'hFFFF00,
                         24'hFF7FFF, 24'hFFFD12, 24'hFFFCFD, 24'hFFFCFE};
        queued_count += addr_pending.size();
        wait_drained();

        for (ph = 0; ph < 12; ph++) begin
            if (ph == 0) begin
                c = '{rom_page: 4'hF, swram_enable: 1'b1, debug_shadow: 1'b1,
                      mos_shadow: 1'b1, turbo_mask: 8'hFF, paging_enable: 1'b1,
                      paging_page: 16'hFFFF, map_select: 1'b1};
            end else if (ph == 1) begin
                c = '0;
            end else begin
                c.rom_page      = 4'($urandom_range(0, 15));
                c.swram_enable  = 1'($urandom_range(0, 1));
                c.debug_shadow  = 1'($urandom_range(0, 1));
                c.mos_shadow    = 1'($urandom_range(0, 1));
                c.turbo_mask    = 8'($urandom_range(0, 255));
                c.paging_enable = 1'($urandom_range(0, 1));
                c.map_select    = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 5))
                    0: c.paging_page = 16'hFEFC;
                    1: c.paging_page = 16'hFFFE;
                    2: c.paging_page = 16'hFFFC;
                    3: c.paging_page = 16'h8000;
                    4: c.paging_page = 16'hFE00;
                    default: c.paging_page = 16'($urandom_range(0, 65535));
                endcase
            end
            idle_on = (ph < 9) && ($urandom_range(0, 3) != 0);
            load_map(c);
            for (k = 0; k < 125; k++) begin
                addr_pending.push_back(rand_addr());
                queued_count++;
                // hold the sender until the unit has emptied out
                if (k == 62 && ph % 2 == 0)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
